FILE: hw/rtl/nbem_pkg.sv
package nbem_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int MACC_W        = 32 + CNT_W;
    localparam int ENTRY_W       = 128;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT = 8'd1;
    localparam logic [31:0] GRAV_RST = 32'h0001_0000;

    localparam int MUL_W   = 33;
    localparam int ROOT_W  = 34;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int RSQ_W   = RAD_W - 2;
    localparam int DIV_N_W = 96;
    localparam int DIV_D_W = 64;

    localparam logic [63:0] TOP63 = 64'h8000_0000_0000_0000;
    localparam logic [62:0] SAT63 = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [31:0] mass;
        logic               present;
        logic               last_particle;
    } t_in_item;

    typedef struct packed {
        logic        [62:0] kinetic_energy;
        logic signed [63:0] potential_energy;
        logic signed [63:0] total_energy;
        logic signed [31:0] com_x;
        logic signed [31:0] com_y;
        logic signed [31:0] com_z;
        logic signed [63:0] momentum_x;
        logic signed [63:0] momentum_y;
        logic signed [63:0] momentum_z;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          value;
    } t_cfg_wr;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAKE,
        S_PAIR_INIT,
        S_RD_I,
        S_LAT_I,
        S_RD_J,
        S_LAT_J,
        S_PMUL,
        S_SQRT,
        S_DIV,
        S_NEXT,
        S_COM,
        S_COM_WAIT,
        S_FIN,
        S_OUT
    } t_state;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s[63:0];
    endfunction

    // acc - m with m <= 2^63, clamps at the most negative value
    function automatic logic signed [63:0] sat_sub_mag(input logic signed [63:0] acc,
                                                       input logic [63:0] m);
        logic signed [64:0] s;
        s = {acc[63], acc} - {1'b0, m};
        if (s[64] && !s[63]) begin
            return 64'sh8000_0000_0000_0000;
        end
        return s[63:0];
    endfunction

endpackage

FILE: hw/rtl/nbem_if.sv
interface nbem_in_if import nbem_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nbem_out_if import nbem_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nbem_cfg_if import nbem_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/nbem_ram.sv
module nbem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/nbem_sqrt.sv
module nbem_sqrt import nbem_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output t_unit_sts         o_sts,
    output logic [ROOT_W-1:0] o_root
);
    localparam int CW = $clog2(ROOT_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              fit;

    // two radicand bits per step, one root bit
    assign rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign diff   = rem_sh - trial;
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= fit ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], fit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_root;
endmodule

FILE: hw/rtl/nbem_div.sv
module nbem_div import nbem_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output t_unit_sts          o_sts,
    output logic [DIV_N_W-1:0] o_quo
);
    localparam int CW = $clog2(DIV_N_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [DIV_N_W-1:0] r_num;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   diff;
    logic               fit;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[DIV_N_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign fit    = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_N_W-2:0], 1'b0};
            r_rem <= fit ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], fit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;
endmodule

FILE: hw/rtl/nbody_energy_momentum_diagnostics_unit.sv
// Sequence: a present particle is accepted, then takes 12 steps on the shared
// 33x33 multiplier; an absent item is only accepted. After the last item, each
// pair i<j uses the multiplier, the square root and, if the root is nonzero, the
// divider; the divider then gives the centre of mass per axis if mass is nonzero.
// Throughput: one item at a time; the result is held until taken.
// Reset: synchronous, active low; resets registers, control, count and accumulators.
module nbody_energy_momentum_diagnostics_unit import nbem_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbem_in_if.sink     i_in,
    nbem_out_if.source  o_out,
    nbem_cfg_if.sink    i_cfg
);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    logic [31:0]        r_grav;
    logic [31:0]        r_soft;

    // set accumulators (cleared by reset and after each result)
    logic [CNT_W-1:0]   r_count;
    logic [62:0]        r_kin;
    logic [MACC_W-1:0]  r_mass;
    logic signed [63:0] r_wpos [3];
    logic signed [63:0] r_mom  [3];
    logic signed [63:0] r_pot;

    // working registers
    t_in_item           r_item;
    logic [3:0]         r_step;
    logic [63:0]        r_vsq;
    logic [63:0]        r_klo;
    logic [2*MUL_W-1:0] r_prod;
    logic [ENTRY_W-1:0] r_pi;
    logic [ENTRY_W-1:0] r_pj;
    logic [63:0]        r_g;
    logic [RSQ_W-1:0]   r_rsq;
    logic [63:0]        r_nlo;
    logic [DIV_N_W-1:0] r_num;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_j;
    logic [1:0]         r_k;
    logic [31:0]        r_com [3];
    t_out_item          r_out;

    // ---------------------------------------------------------------
    // Units
    // ---------------------------------------------------------------
    logic               st_we;
    logic [IDX_W-1:0]   st_raddr;
    logic [ENTRY_W-1:0] st_wdata;
    logic [ENTRY_W-1:0] st_rdata;

    logic               sq_start;
    t_unit_sts          sq_sts;
    logic [ROOT_W-1:0]  sq_root;

    logic               dv_start;
    logic [DIV_N_W-1:0] dv_num;
    logic [DIV_D_W-1:0] dv_den;
    t_unit_sts          dv_sts;
    logic [DIV_N_W-1:0] dv_quo;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;

    logic               in_acc;
    logic               out_acc;
    logic               full;

    // particle store: {mass, pos_z, pos_y, pos_x}
    nbem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    nbem_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   ({2'b00, r_rsq}),
        .o_sts   (sq_sts),
        .o_root  (sq_root)
    );

    nbem_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_sts   (dv_sts),
        .o_quo   (dv_quo)
    );

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    // signed product from magnitude product; magnitude < 2^63
    function automatic logic signed [63:0] sterm(input logic neg,
                                                 input logic [2*MUL_W-1:0] p);
        logic [63:0] t;
        t = {1'b0, p[62:0]};
        return neg ? (64'd0 - t) : t;
    endfunction

    // centre of mass: quotient magnitude clamped into 32-bit signed
    function automatic logic [31:0] com_cap(input logic neg,
                                            input logic [DIV_N_W-1:0] q);
        logic big_n;
        logic big_p;
        big_n = (q[DIV_N_W-1:32] != '0) || (q[31:0] > 32'h8000_0000);
        big_p = (q[DIV_N_W-1:31] != '0);
        if (neg) begin
            return big_n ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end
        return big_p ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function automatic logic [MUL_W-1:0] dmag(input logic [31:0] pj,
                                              input logic [31:0] pi);
        logic [MUL_W-1:0] d;
        d = {pj[31], pj} - {pi[31], pi};
        return d[MUL_W-1] ? (MUL_W'(0) - d) : d;
    endfunction

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data  = r_out;
    assign out_acc     = o_out.valid && o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign full        = (r_count >= CNT_W'(MAX_PARTICLES));

    assign st_wdata = {r_item.mass, r_item.pos_z, r_item.pos_y, r_item.pos_x};

    // ---------------------------------------------------------------
    // Shared multiplier operands
    // ---------------------------------------------------------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_TAKE) begin
            unique case (r_step)
                4'd0: begin
                    mul_a = {1'b0, mag32(r_item.vel_x)};
                    mul_b = mul_a;
                end
                4'd1: begin
                    mul_a = {1'b0, mag32(r_item.vel_y)};
                    mul_b = mul_a;
                end
                4'd2: begin
                    mul_a = {1'b0, mag32(r_item.vel_z)};
                    mul_b = mul_a;
                end
                4'd3: mul_a = {1'b0, mag32(r_item.pos_x)};
                4'd4: mul_a = {1'b0, mag32(r_item.pos_y)};
                4'd5: mul_a = {1'b0, mag32(r_item.pos_z)};
                4'd6: mul_a = {1'b0, mag32(r_item.vel_x)};
                4'd7: mul_a = {1'b0, mag32(r_item.vel_y)};
                4'd8: mul_a = {1'b0, mag32(r_item.vel_z)};
                4'd9: mul_a = {1'b0, r_vsq[31:0]};
                4'd10: mul_a = {1'b0, r_vsq[63:32]};
                default: mul_a = '0;
            endcase
            if (r_step >= 4'd3) begin
                mul_b = {1'b0, r_item.mass};
            end
        end else if (r_state == S_PMUL) begin
            unique case (r_step)
                4'd0: begin
                    mul_a = dmag(r_pj[31:0], r_pi[31:0]);
                    mul_b = mul_a;
                end
                4'd1: begin
                    mul_a = dmag(r_pj[63:32], r_pi[63:32]);
                    mul_b = mul_a;
                end
                4'd2: begin
                    mul_a = dmag(r_pj[95:64], r_pi[95:64]);
                    mul_b = mul_a;
                end
                4'd3: begin
                    mul_a = {1'b0, r_grav};
                    mul_b = {1'b0, r_pi[127:96]};
                end
                4'd4: begin
                    mul_a = {1'b0, r_prod[31:0]};
                    mul_b = {1'b0, r_pj[127:96]};
                end
                4'd5: begin
                    mul_a = {1'b0, r_g[63:32]};
                    mul_b = {1'b0, r_pj[127:96]};
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        st_we    = 1'b0;
        st_raddr = r_i[IDX_W-1:0];
        sq_start = 1'b0;
        dv_start = 1'b0;
        dv_num   = r_num;
        dv_den   = DIV_D_W'(sq_root);
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.data.present && !full) begin
                        n_state = S_TAKE;
                    end else if (i_in.data.last_particle) begin
                        n_state = S_PAIR_INIT;
                    end
                end
            end
            S_TAKE: begin
                if (r_step == 4'd11) begin
                    st_we   = 1'b1;
                    n_state = r_item.last_particle ? S_PAIR_INIT : S_IDLE;
                end
            end
            S_PAIR_INIT: begin
                n_state = (r_count < CNT_W'(2)) ? S_COM : S_RD_I;
            end
            S_RD_I: begin
                n_state = S_LAT_I;
            end
            S_LAT_I: begin
                n_state = S_RD_J;
            end
            S_RD_J: begin
                st_raddr = r_j[IDX_W-1:0];
                n_state  = S_LAT_J;
            end
            S_LAT_J: begin
                n_state = S_PMUL;
            end
            S_PMUL: begin
                if (r_step == 4'd6) begin
                    sq_start = 1'b1;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sq_sts.done) begin
                    if (sq_root == '0) begin
                        n_state = S_NEXT;
                    end else begin
                        dv_start = 1'b1;
                        n_state  = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (dv_sts.done) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if ((r_j + 1'b1) < r_count) begin
                    n_state = S_RD_J;
                end else if ((r_i + CNT_W'(2)) < r_count) begin
                    n_state = S_RD_I;
                end else begin
                    n_state = S_COM;
                end
            end
            S_COM: begin
                if (r_mass == '0) begin
                    n_state = S_FIN;
                end else begin
                    dv_start = 1'b1;
                    dv_num   = DIV_N_W'(mag64(r_wpos[r_k]));
                    dv_den   = DIV_D_W'(r_mass);
                    n_state  = S_COM_WAIT;
                end
            end
            S_COM_WAIT: begin
                if (dv_sts.done) begin
                    n_state = (r_k == 2'd2) ? S_FIN : S_COM;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Configuration and set accumulators
    // ---------------------------------------------------------------
    logic [95:0] ke_full;
    logic [62:0] ke;
    logic [63:0] kin_sum;
    logic [63:0] pair_mag;

    assign ke_full  = {r_prod[63:0], 32'd0} + {32'd0, r_klo};
    assign ke       = (ke_full[95:80] != '0) ? SAT63 : ke_full[79:17];
    assign kin_sum  = {1'b0, r_kin} + {1'b0, ke};
    // pair term floor(G*mi*mj/d), capped at 2^63
    assign pair_mag = ((dv_quo[DIV_N_W-1:64] != '0) || (dv_quo[63:0] > TOP63)) ?
                      TOP63 : dv_quo[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav  <= GRAV_RST;
            r_soft  <= '0;
            r_count <= '0;
            r_kin   <= '0;
            r_mass  <= '0;
            r_pot   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_wpos[k] <= '0;
                r_mom[k]  <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.data.index == CFG_GRAV) begin
                    r_grav <= i_cfg.data.value;
                end else if (i_cfg.data.index == CFG_SOFT) begin
                    r_soft <= i_cfg.data.value;
                end
            end
            if (r_state == S_TAKE) begin
                unique case (r_step)
                    4'd4: r_wpos[0] <= sat_add64(r_wpos[0], sterm(r_item.pos_x[31], r_prod));
                    4'd5: r_wpos[1] <= sat_add64(r_wpos[1], sterm(r_item.pos_y[31], r_prod));
                    4'd6: r_wpos[2] <= sat_add64(r_wpos[2], sterm(r_item.pos_z[31], r_prod));
                    4'd7: r_mom[0]  <= sat_add64(r_mom[0], sterm(r_item.vel_x[31], r_prod));
                    4'd8: r_mom[1]  <= sat_add64(r_mom[1], sterm(r_item.vel_y[31], r_prod));
                    4'd9: r_mom[2]  <= sat_add64(r_mom[2], sterm(r_item.vel_z[31], r_prod));
                    4'd11: begin
                        r_kin   <= kin_sum[63] ? SAT63 : kin_sum[62:0];
                        r_mass  <= r_mass + MACC_W'(r_item.mass);
                        r_count <= r_count + 1'b1;
                    end
                    default: ;
                endcase
            end
            if (r_state == S_DIV && dv_sts.done) begin
                r_pot <= sat_sub_mag(r_pot, pair_mag);
            end
            // set done: back to empty for the next one
            if (out_acc) begin
                r_count <= '0;
                r_kin   <= '0;
                r_mass  <= '0;
                r_pot   <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_wpos[k] <= '0;
                    r_mom[k]  <= '0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Working registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= {MUL_W'(0), mul_a} * {MUL_W'(0), mul_b};
        unique case (r_state)
            S_IDLE: begin
                r_item <= i_in.data;
                r_step <= '0;
                r_vsq  <= '0;
            end
            S_TAKE: begin
                r_step <= r_step + 1'b1;
                if (r_step >= 4'd1 && r_step <= 4'd3) begin
                    r_vsq <= r_vsq + r_prod[63:0];
                end
                if (r_step == 4'd10) begin
                    r_klo <= r_prod[63:0];
                end
            end
            S_PAIR_INIT: begin
                r_i <= '0;
                r_k <= '0;
            end
            S_RD_I: begin
                r_j <= r_i + 1'b1;
            end
            S_LAT_I: begin
                r_pi <= st_rdata;
            end
            S_LAT_J: begin
                r_pj   <= st_rdata;
                r_step <= '0;
                r_rsq  <= {18'd0, r_soft, 16'd0};
            end
            S_PMUL: begin
                r_step <= r_step + 1'b1;
                if (r_step >= 4'd1 && r_step <= 4'd3) begin
                    r_rsq <= r_rsq + RSQ_W'(r_prod);
                end
                if (r_step == 4'd4) begin
                    r_g <= r_prod[63:0];
                end
                if (r_step == 4'd5) begin
                    r_nlo <= r_prod[63:0];
                end
                if (r_step == 4'd6) begin
                    r_num <= {r_prod[63:0], 32'd0} + {32'd0, r_nlo};
                end
            end
            S_NEXT: begin
                if ((r_j + 1'b1) < r_count) begin
                    r_j <= r_j + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_COM: begin
                if (r_mass == '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_com[k] <= '0;
                    end
                end
            end
            S_COM_WAIT: begin
                if (dv_sts.done) begin
                    r_com[r_k] <= com_cap(r_wpos[r_k][63], dv_quo);
                    r_k        <= r_k + 1'b1;
                end
            end
            S_FIN: begin
                r_out.kinetic_energy   <= r_kin;
                r_out.potential_energy <= r_pot;
                r_out.total_energy     <= sat_add64({1'b0, r_kin}, r_pot);
                r_out.com_x            <= r_com[0];
                r_out.com_y            <= r_com[1];
                r_out.com_z            <= r_com[2];
                r_out.momentum_x       <= r_mom[0];
                r_out.momentum_y       <= r_mom[1];
                r_out.momentum_z       <= r_mom[2];
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PARTICLES))
        else $error("particle count above store depth");

    a_pot_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pot[63] || r_pot == '0))
        else $error("potential energy became positive");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAT_J || r_state == S_PMUL) |-> (r_i < r_j && r_j < r_count))
        else $error("pair indices out of order or range");

    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> (r_count == '0 && r_mass == '0 && r_pot == '0))
        else $error("set state not cleared after result");

    a_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sq_start || dv_start) |-> (!sq_sts.busy && !dv_sts.busy))
        else $error("arithmetic unit started while busy");
`endif

endmodule

FILE: test/nbem_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, predicts each set's energy and momentum summary
// and compares it with what the unit sends out.
module nbem_checker import nbem_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  t_cfg_wr   i_cfg_data,
    output int        o_errors,
    output int        o_pending
);

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    logic [31:0]        grav;
    logic [31:0]        soft_sq;
    logic signed [31:0] body_pos [MAX_PARTICLES][3];
    logic [31:0]        body_mass [MAX_PARTICLES];
    int                 body_cnt;
    logic [63:0]        ke_sum;
    logic [63:0]        mass_sum;
    logic signed [63:0] wpos_sum [3];
    logic signed [63:0] mom_sum [3];
    logic signed [63:0] pot_sum;
    t_out_item          summary_q [$];
    int                 errors;

    function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(S64_MAX)) return S64_MAX;
        if (s < 65'(S64_MIN)) return S64_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] drop_by(input logic signed [63:0] acc,
                                                   input logic [63:0] m);
        logic signed [65:0] s;
        s = 66'(acc) - $signed({2'b00, m});
        if (s < 66'(S64_MIN)) return S64_MIN;
        return s[63:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] n);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= n) r = c;
        end
        return r[63:0];
    endfunction

    function automatic logic [31:0] centre(input logic signed [63:0] w);
        logic [63:0] mag;
        logic [63:0] q;
        if (mass_sum == 0) return '0;
        mag = w < 0 ? 64'(-w) : 64'(w);
        q = mag / mass_sum;
        if (w < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(64'd0 - q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic void clear_set();
        body_cnt = 0;
        ke_sum   = '0;
        mass_sum = '0;
        pot_sum  = '0;
        for (int k = 0; k < 3; k++) begin
            wpos_sum[k] = '0;
            mom_sum[k]  = '0;
        end
    endfunction

    function automatic void take_body(input t_in_item it);
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        logic signed [63:0] vv;
        logic signed [63:0] pv;
        logic signed [63:0] ms;
        logic [63:0]        a;
        logic [63:0]        vsq;
        logic [127:0]       prod;
        logic [64:0]        s;
        if (body_cnt >= MAX_PARTICLES) return;
        p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
        v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
        ms  = $signed({32'd0, it.mass});
        vsq = '0;
        for (int k = 0; k < 3; k++) begin
            vv  = v[k];
            pv  = p[k];
            a   = vv < 0 ? 64'(-vv) : 64'(vv);
            vsq = vsq + a * a;
            body_pos[body_cnt][k] = p[k];
            wpos_sum[k] = clamp_add(wpos_sum[k], pv * ms);
            mom_sum[k]  = clamp_add(mom_sum[k], vv * ms);
        end
        body_mass[body_cnt] = it.mass;
        body_cnt++;
        mass_sum = mass_sum + 64'(it.mass);
        prod = 128'(it.mass) * 128'(vsq);
        prod = prod >> 17;
        if (prod > 128'(SAT63)) prod = 128'(SAT63);
        s = 65'(ke_sum) + 65'(prod[63:0]);
        ke_sum = s > 65'(SAT63) ? 64'(SAT63) : s[63:0];
    endfunction

    function automatic void sum_pairs();
        logic signed [32:0] dx;
        logic [32:0]        ad;
        logic [127:0]       r;
        logic [63:0]        d;
        logic [127:0]       q;
        for (int i = 0; i < body_cnt; i++) begin
            for (int j = i + 1; j < body_cnt; j++) begin
                r = 128'(soft_sq) << 16;
                for (int k = 0; k < 3; k++) begin
                    dx = 33'(body_pos[j][k]) - 33'(body_pos[i][k]);
                    ad = dx < 0 ? 33'(-dx) : 33'(dx);
                    r  = r + 128'(ad) * 128'(ad);
                end
                d = root_floor(r);
                // coincident bodies with no softening contribute nothing
                if (d == 0) continue;
                q = 128'(grav) * 128'(body_mass[i]) * 128'(body_mass[j]) / 128'(d);
                if (q > 128'(TOP63)) q = 128'(TOP63);
                pot_sum = drop_by(pot_sum, q[63:0]);
            end
        end
    endfunction

    function automatic t_out_item close_set();
        t_out_item o;
        sum_pairs();
        o.kinetic_energy   = ke_sum[62:0];
        o.potential_energy = pot_sum;
        o.total_energy     = clamp_add($signed(ke_sum), pot_sum);
        o.com_x            = centre(wpos_sum[0]);
        o.com_y            = centre(wpos_sum[1]);
        o.com_z            = centre(wpos_sum[2]);
        o.momentum_x       = mom_sum[0];
        o.momentum_y       = mom_sum[1];
        o.momentum_z       = mom_sum[2];
        clear_set();
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t: %s expected %h got %h", $realtime, name, exp_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            grav    = GRAV_RST;
            soft_sq = '0;
            errors  = 0;
            summary_q.delete();
            clear_set();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_data.index == CFG_GRAV) grav = i_cfg_data.value;
                else if (i_cfg_data.index == CFG_SOFT) soft_sq = i_cfg_data.value;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.present) take_body(i_in_data);
                if (i_in_data.last_particle) summary_q.push_back(close_set());
            end
            if (i_out_valid && i_out_ready) begin
                if (summary_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $realtime, i_out_data);
                end else begin
                    e = summary_q.pop_front();
                    check_field("kinetic", 64'(e.kinetic_energy),
                                64'(i_out_data.kinetic_energy));
                    check_field("potential", e.potential_energy,
                                i_out_data.potential_energy);
                    check_field("total", e.total_energy, i_out_data.total_energy);
                    check_field("com_x", 64'(e.com_x), 64'(i_out_data.com_x));
                    check_field("com_y", 64'(e.com_y), 64'(i_out_data.com_y));
                    check_field("com_z", 64'(e.com_z), 64'(i_out_data.com_z));
                    check_field("momentum_x", e.momentum_x, i_out_data.momentum_x);
                    check_field("momentum_y", e.momentum_y, i_out_data.momentum_y);
                    check_field("momentum_z", e.momentum_z, i_out_data.momentum_z);
                end
            end
        end
        o_errors  <= errors;
        o_pending <= summary_q.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the n-body diagnostics unit. The checker beside the
// unit does all prediction; this module drives the channels and reports.
module testbench;
    import nbem_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 8'd7;   // unmapped register index
    localparam logic signed [31:0]   POS_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   POS_MIN  = 32'sh8000_0000;
    localparam int                   ITEM_GOAL = 1150;

    logic i_clk;
    logic i_rst_n;
    int   tx_idle;     // percent of cycles the sender holds off
    int   rx_idle;     // percent of cycles the receiver holds off
    int   n_items;     // items sent so far
    int   errors;
    int   pending;

    nbem_in_if  in_ch ();
    nbem_out_if out_ch ();
    nbem_cfg_if cfg_ch ();

    nbody_energy_momentum_diagnostics_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    nbem_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .i_cfg_valid (cfg_ch.valid),
        .i_cfg_ready (cfg_ch.ready),
        .i_cfg_data  (cfg_ch.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sink side: random back-pressure at the current rate.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    // Hard stop, well past the slowest legal run.
    initial begin
        #40_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic t_in_item body(input logic [31:0] px, py, pz, vx, vy, vz, m,
                                      input logic pres, input logic last);
        t_in_item it;
        it.pos_x = px; it.pos_y = py; it.pos_z = pz;
        it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
        it.mass = m;
        it.present = pres;
        it.last_particle = last;
        return it;
    endfunction

    // One item on the input channel. Valid stays up across back-to-back items.
    task automatic put(input t_in_item it);
        while ($urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        n_items++;
    endtask

    // Registers only change with the unit idle: drain, let it settle, then write.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(7))
            0, 1:    return $urandom;
            2:       return '0;
            3:       return '1;
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    // One random set: clustered sets give short, nonzero or zero distances,
    // wide sets exercise the full coordinate range.
    task automatic random_set(input int n);
        logic [31:0] ctr [3];
        logic [31:0] p [3];
        logic [31:0] v [3];
        bit          wide;
        bit          slow;
        bit          pres;
        wide = $urandom_range(2) == 0;
        slow = $urandom_range(1) == 0;
        for (int k = 0; k < 3; k++) ctr[k] = $urandom;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++) begin
                p[k] = wide ? $urandom : ctr[k] + $urandom_range(0, 8) - 4;
                v[k] = slow ? $urandom_range(0, 32'h0004_0000) - 32'h0002_0000 : $urandom;
            end
            pres = $urandom_range(99) < 85;
            put(body(p[0], p[1], p[2], v[0], v[1], v[2], pick_mass(), pres, i == n - 1));
        end
    endtask

    task automatic random_regs();
        logic [31:0] g;
        logic [31:0] e;
        case ($urandom_range(3))
            0:       g = '0;
            1:       g = '1;
            2:       g = GRAV_RST;
            default: g = $urandom;
        endcase
        case ($urandom_range(3))
            0:       e = '0;
            1:       e = '1;
            2:       e = $urandom_range(0, 32'h0001_0000);
            default: e = $urandom;
        endcase
        reg_write(CFG_GRAV, g);
        reg_write(CFG_SOFT, e);
    endtask

    initial begin
        int sets;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        i_rst_n      = 1'b0;
        tx_idle      = 32;
        rx_idle      = 46;
        n_items      = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty set: a lone absent last item, everything zero.
        put(body('0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        // Single heavy fast body at the coordinate corners: kinetic saturates.
        put(body(POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MIN, POS_MIN, '1, 1'b1, 1'b1));
        // Coincident bodies, then an absent last item closes the set.
        put(body(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0001_0000, '0, '0,
                 32'h0002_0000, 1'b1, 1'b0));
        put(body(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, '0, 32'hFFFF_0000, '0,
                 32'h0003_0000, 1'b1, 1'b0));
        put(body('0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        // Momentum and weighted position piling up past the signed range.
        put(body(POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MIN, POS_MAX, '1, 1'b1, 1'b0));
        put(body(POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MIN, POS_MAX, '1, 1'b1, 1'b0));
        put(body(POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MAX, POS_MIN, '1, 1'b1, 1'b1));

        // Huge G, bodies one step apart: pair terms cap and the potential bottoms out.
        reg_write(CFG_GRAV, '1);
        reg_write(CFG_SOFT, '0);
        put(body('0, '0, '0, '0, '0, '0, '1, 1'b1, 1'b0));
        put(body(32'h1, '0, '0, '0, '0, '0, '1, 1'b1, 1'b0));
        put(body('0, 32'h1, '0, '0, '0, '0, '1, 1'b1, 1'b0));
        put(body('0, '0, 32'h1, POS_MAX, POS_MAX, POS_MAX, '1, 1'b1, 1'b1));
        // Full softening, an ignored register write, then no gravity at all.
        reg_write(CFG_SOFT, '1);
        reg_write(CFG_NONE, 32'hDEAD_BEEF);
        put(body('0, '0, '0, '0, '0, '0, '1, 1'b1, 1'b0));
        put(body('0, '0, '0, '0, '0, '0, '1, 1'b1, 1'b1));
        reg_write(CFG_GRAV, '0);
        put(body(32'h0001_0000, '0, '0, '0, '0, '0, 32'h0001_0000, 1'b1, 1'b0));
        put(body('0, '0, '0, '0, '0, '0, 32'h0001_0000, 1'b1, 1'b1));
        reg_write(CFG_GRAV, GRAV_RST);
        reg_write(CFG_SOFT, '0);

        // Three idling phases; registers shuffled every dozen sets or so.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                tx_idle = 46;
                rx_idle = 32;
            end else if (ph == 2) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            sets = 0;
            while (n_items < ITEM_GOAL * (ph + 1) / 3) begin
                if (sets % 12 == 11) random_regs();
                // mostly small sets; the odd larger one for longer pair sweeps
                random_set($urandom_range(99) < 3 ? 24 : $urandom_range(1, 8));
                sets++;
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/nbem_pkg.sv
hw/rtl/nbem_if.sv
hw/rtl/nbem_ram.sv
hw/rtl/nbem_sqrt.sv
hw/rtl/nbem_div.sv
hw/rtl/nbody_energy_momentum_diagnostics_unit.sv
test/nbem_checker.sv
test/testbench.sv
